### rtl/core/tld_pkg.sv
`timescale 1ns / 1ps

package tld_pkg;

    // Character codes handled by the line discipline.
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_INTERRUPT = 8'h03;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_NONE      = 8'h00;

    // Source of an input byte.
    localparam logic KIND_KEYBOARD = 1'b0;
    localparam logic KIND_PROGRAM  = 1'b1;

    // Destination of a result byte.
    localparam logic DEST_DISPLAY = 1'b0;
    localparam logic DEST_READER  = 1'b1;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_ENABLE      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANONICAL_ENABLE = 1'd1;

    // Access strobes from the sequencer to the line store.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

### rtl/core/tld_store.sv
`timescale 1ns / 1ps

module tld_store #(
    parameter int LINE_DEPTH = 32
) (
    input  logic                            aclk,
    input  tld_pkg::mem_ctl_t               mem_ctl,
    input  logic [$clog2(LINE_DEPTH)-1:0]   wr_addr,
    input  logic [7:0]                      wr_data,
    input  logic [$clog2(LINE_DEPTH)-1:0]   rd_addr,
    output logic [7:0]                      rd_data
);
    import tld_pkg::*;

    logic [7:0] mem [LINE_DEPTH];
    logic [7:0] rd_data_reg;

    // Read data is registered and holds its value while no read is issued.
    always_ff @(posedge aclk) begin
        if (mem_ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_ctl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/tld_seq.sv
`timescale 1ns / 1ps

module tld_seq #(
    parameter int LINE_DEPTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            echo_enable,
    input  logic                            canonical_enable,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_kind,
    input  logic [7:0]                      s_in_byte,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_destination,
    output logic [7:0]                      m_out_byte,
    output logic                            m_last,
    output logic                            m_overflow,
    output tld_pkg::mem_ctl_t               mem_ctl,
    output logic [$clog2(LINE_DEPTH)-1:0]   wr_addr,
    output logic [7:0]                      wr_data,
    output logic [$clog2(LINE_DEPTH)-1:0]   rd_addr,
    input  logic [7:0]                      rd_data
);
    import tld_pkg::*;

    localparam int LEN_W  = $clog2(LINE_DEPTH + 1);
    localparam int ADDR_W = $clog2(LINE_DEPTH);
    localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(LINE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ECHO,
        S_FLUSH,
        S_FLAG
    } state_t;

    typedef enum logic {
        ECHO_ONE,
        ECHO_ERASE
    } echo_mode_t;

    state_t             state_reg, state_next;
    echo_mode_t         mode_reg, mode_next;
    logic [1:0]         step_reg, step_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   flush_cnt_reg, flush_cnt_next;
    logic [LEN_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               pend_reg, pend_next;
    logic               ovf_reg, ovf_next;
    logic [7:0]         byte_reg, byte_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_dest_reg, out_dest_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               out_last_reg, out_last_next;
    logic               out_ovf_reg, out_ovf_next;

    logic               accept;
    logic               slot_free;
    logic               load;
    logic               is_kbd;
    logic               erase;
    logic               len_nz;
    logic               full;
    logic               echo;
    logic               dropped;
    logic               append;
    logic               flush;
    logic [LEN_W-1:0]   new_len;
    logic [LEN_W-1:0]   acc_flush_cnt;
    logic               flag_only;
    logic               echo_final;

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign slot_free = !out_valid_reg || m_ready;

    // Decode of the item at the input, against the current line length.
    always_comb begin
        is_kbd  = (s_kind == KIND_KEYBOARD);
        erase   = is_kbd && canonical_enable && (s_in_byte == CH_BACKSPACE);
        len_nz  = (len_reg != '0);
        full    = (len_reg >= DEPTH_LEN);
        echo    = !is_kbd || (echo_enable && (erase ? len_nz : 1'b1));
        dropped = is_kbd && !erase && full;
        append  = is_kbd && !erase && !full;
        if (erase && len_nz) begin
            new_len = len_reg - LEN_W'(1);
        end else if (append) begin
            new_len = len_reg + LEN_W'(1);
        end else begin
            new_len = len_reg;
        end
        flush = is_kbd && ((s_in_byte == CH_NEWLINE) || (s_in_byte == CH_INTERRUPT)
                || !canonical_enable);
        acc_flush_cnt = flush ? new_len : '0;
        flag_only     = dropped && !echo && (acc_flush_cnt == '0);
    end

    assign echo_final = (mode_reg == ECHO_ONE) || (step_reg == 2'd2);

    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        step_next      = step_reg;
        len_next       = len_reg;
        flush_cnt_next = flush_cnt_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        ovf_next       = ovf_reg;
        byte_next      = byte_reg;

        out_valid_next = out_valid_reg && !m_ready;
        out_dest_next  = out_dest_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        load           = 1'b0;

        mem_ctl.wr_en  = 1'b0;
        mem_ctl.rd_en  = 1'b0;
        wr_addr        = len_reg[ADDR_W-1:0];
        wr_data        = s_in_byte;
        rd_addr        = rd_idx_reg[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    byte_next      = s_in_byte;
                    mode_next      = erase ? ECHO_ERASE : ECHO_ONE;
                    step_next      = 2'd0;
                    ovf_next       = dropped;
                    flush_cnt_next = acc_flush_cnt;
                    rd_idx_next    = '0;
                    pend_next      = 1'b0;
                    mem_ctl.wr_en  = append;
                    if (is_kbd) begin
                        len_next = flush ? '0 : new_len;
                    end
                    if (echo) begin
                        state_next = S_ECHO;
                    end else if (acc_flush_cnt != '0) begin
                        state_next = S_FLUSH;
                    end else if (flag_only) begin
                        state_next = S_FLAG;
                    end
                end
            end
            S_ECHO: begin
                if (slot_free) begin
                    load          = 1'b1;
                    out_dest_next = DEST_DISPLAY;
                    if (mode_reg == ECHO_ONE) begin
                        out_byte_next = byte_reg;
                    end else if (step_reg == 2'd1) begin
                        out_byte_next = CH_SPACE;
                    end else begin
                        out_byte_next = CH_BACKSPACE;
                    end
                    out_last_next = echo_final && (flush_cnt_reg == '0);
                    out_ovf_next  = ovf_reg;
                    if (echo_final) begin
                        state_next = (flush_cnt_reg != '0) ? S_FLUSH : S_IDLE;
                    end else begin
                        step_next = step_reg + 2'd1;
                    end
                end
            end
            S_FLUSH: begin
                if (!pend_reg) begin
                    // First read of the line; data shows up next cycle.
                    mem_ctl.rd_en = 1'b1;
                    pend_next     = 1'b1;
                    rd_idx_next   = rd_idx_reg + LEN_W'(1);
                end else if (slot_free) begin
                    load          = 1'b1;
                    out_dest_next = DEST_READER;
                    out_byte_next = rd_data;
                    out_last_next = (rd_idx_reg == flush_cnt_reg);
                    out_ovf_next  = ovf_reg;
                    if (rd_idx_reg == flush_cnt_reg) begin
                        pend_next  = 1'b0;
                        state_next = S_IDLE;
                    end else begin
                        mem_ctl.rd_en = 1'b1;
                        rd_idx_next   = rd_idx_reg + LEN_W'(1);
                    end
                end
            end
            S_FLAG: begin
                if (slot_free) begin
                    load          = 1'b1;
                    out_dest_next = DEST_DISPLAY;
                    out_byte_next = CH_NONE;
                    out_last_next = 1'b1;
                    out_ovf_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
        mode_reg      <= mode_next;
        step_reg      <= step_next;
        flush_cnt_reg <= flush_cnt_next;
        rd_idx_reg    <= rd_idx_next;
        ovf_reg       <= ovf_next;
        byte_reg      <= byte_next;
        out_dest_reg  <= out_dest_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_destination = out_dest_reg;
    assign m_out_byte    = out_byte_reg;
    assign m_last        = out_last_reg;
    assign m_overflow    = out_ovf_reg;

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= DEPTH_LEN)
        else $error("line length beyond store depth");

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_ctl.wr_en && mem_ctl.rd_en))
        else $error("store written and read in the same cycle");

    a_flush_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FLUSH && pend_reg) |->
        (rd_idx_reg != '0 && rd_idx_reg <= flush_cnt_reg))
        else $error("flush read index out of range");

    a_last_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && out_last_next) |=> (state_reg == S_IDLE))
        else $error("final result issued while the item is still active");

endmodule

### rtl/core/tty_line_discipline.sv
`timescale 1ns / 1ps

// Terminal line discipline. Keyboard bytes (s_kind 0) are echoed to the display
// (m_destination 0) while echo_enable is set; in canonical mode a backspace
// echoes backspace, space, backspace and erases the last stored byte, only when
// the line holds something. Other keyboard bytes are appended to an on-chip line
// store of LINE_DEPTH bytes; a newline or 0x03, or any keyboard byte when
// canonical mode is off, then sends the whole stored line, terminator included,
// to the reader (m_destination 1). A byte that finds the line full is dropped
// and every result of that transaction carries m_overflow; if it causes no other
// result, a single flag-only result with byte 0 is sent. Program-output bytes
// (s_kind 1) go straight to the display. m_last marks the final result of each
// input transaction; some transactions (a backspace on an empty line, or an
// appended byte that starts no flush, with echo off) produce no result at all.
// Sequence: s_ready is high only between items. A program byte is accepted,
// then emitted. A keyboard byte is accepted, then its echoed bytes (1 or 3) are
// emitted, then, for a line flush, the store is read; its read port is
// registered, so the first address is issued before any line byte can be sent,
// and the line then streams one byte per cycle while the output is not stalled.
// A dropped byte that causes neither an echo nor a flush emits its flag-only
// result after the accept. Cycles with m_ready low stall the results. The result
// register lets an item be taken while the previous result waits. Configuration registers
// (index 0 echo_enable, index 1 canonical_enable, both reset to 1) accept writes
// in any cycle and should be written only while the block is idle.

module tty_line_discipline #(
    parameter int LINE_DEPTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tld_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic                            cfg_wdata,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_kind,
    input  logic [7:0]                      s_in_byte,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_destination,
    output logic [7:0]                      m_out_byte,
    output logic                            m_last,
    output logic                            m_overflow
);
    import tld_pkg::*;

    localparam int ADDR_W = $clog2(LINE_DEPTH);

    logic               echo_enable_reg;
    logic               canonical_enable_reg;

    mem_ctl_t           mem_ctl;
    logic [ADDR_W-1:0]  wr_addr;
    logic [7:0]         wr_data;
    logic [ADDR_W-1:0]  rd_addr;
    logic [7:0]         rd_data;

    // The configuration channel never stalls; each accepted write goes straight into its register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_enable_reg      <= 1'b1;
            canonical_enable_reg <= 1'b1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ECHO_ENABLE:      echo_enable_reg      <= cfg_wdata;
                CFG_CANONICAL_ENABLE: canonical_enable_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // The sequencer decides what each item does, keeps the line length and
    // drives the result register; the store holds the line bytes.
    tld_seq #(
        .LINE_DEPTH(LINE_DEPTH)
    ) u_seq (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .echo_enable      (echo_enable_reg),
        .canonical_enable (canonical_enable_reg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_in_byte        (s_in_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_destination    (m_destination),
        .m_out_byte       (m_out_byte),
        .m_last           (m_last),
        .m_overflow       (m_overflow),
        .mem_ctl          (mem_ctl),
        .wr_addr          (wr_addr),
        .wr_data          (wr_data),
        .rd_addr          (rd_addr),
        .rd_data          (rd_data)
    );

    tld_store #(
        .LINE_DEPTH(LINE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .mem_ctl (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
